@@ rtl/http_header_stream_parser_macros.svh @@
// ----------------------------------------------------------------------------
// http header stream parser assertion macros
// shared property forms for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_STREAM_PARSER_MACROS_SVH
`define HTTP_HEADER_STREAM_PARSER_MACROS_SVH

// same-cycle implication
`define HHSP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hhsp assertion failed");

// next-cycle implication
`define HHSP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hhsp assertion failed");

`endif

@@ rtl/hhsp_pkg.sv @@
// ----------------------------------------------------------------------------
// hhsp_pkg
// types, codes and name tables of the http header stream parser
// ----------------------------------------------------------------------------
package hhsp_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_RESPONSE_MODE = 1'b0;

    // status codes
    localparam logic [1:0] ST_PARSING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // byte roles
    localparam logic [2:0] ROLE_FIRST  = 3'd0;
    localparam logic [2:0] ROLE_MIDDLE = 3'd1;
    localparam logic [2:0] ROLE_LAST   = 3'd2;
    localparam logic [2:0] ROLE_NAME   = 3'd3;
    localparam logic [2:0] ROLE_SEP    = 3'd4;
    localparam logic [2:0] ROLE_VALUE  = 3'd5;
    localparam logic [2:0] ROLE_EOL    = 3'd6;

    // characters
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
    localparam logic [7:0] HIGH_ASCII = 8'h7f;

    // name and word tables, lower case, and the upper-case version text
    localparam logic [4:0] TE_LEN    = 5'd17;
    localparam logic [4:0] CL_LEN    = 5'd14;
    localparam logic [4:0] CHUNK_LEN = 5'd7;
    localparam logic [3:0] VERS_LEN  = 4'd7;
    localparam logic [3:0] VERS_COLS = 4'd8;
    localparam logic [3:0] COL_MAX   = 4'hf;
    localparam logic [4:0] MI_MAX    = 5'd31;

    localparam logic [7:0] TE_NAME [17] = '{
        "t", "r", "a", "n", "s", "f", "e", "r", "-",
        "e", "n", "c", "o", "d", "i", "n", "g"
    };
    localparam logic [7:0] CL_NAME [14] = '{
        "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"
    };
    localparam logic [7:0] CHUNK_WORD [7] = '{"c", "h", "u", "n", "k", "e", "d"};
    localparam logic [7:0] VERS_TEXT [7] = '{"H", "T", "T", "P", "/", "1", "."};

    // line phase
    typedef enum logic [5:0] {
        PH_F0    = 6'b000001,
        PH_F1    = 6'b000010,
        PH_F2    = 6'b000100,
        PH_NAME  = 6'b001000,
        PH_VSKIP = 6'b010000,
        PH_VALUE = 6'b100000
    } t_phase;

    // one registered input transaction
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       start_of_message;
    } t_in_item;

endpackage

@@ rtl/hhsp_apb_regs.sv @@
// ----------------------------------------------------------------------------
// hhsp_apb_regs
// apb configuration register: response_mode at word 0
// ----------------------------------------------------------------------------
module hhsp_apb_regs
    import hhsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_response_mode
);

    logic r_response_mode;
    logic w_sel_mode;
    logic w_write;

    assign w_sel_mode = (paddr[APB_ADDR_W-1:2] == REG_RESPONSE_MODE);
    assign w_write    = psel && penable && pwrite;
    assign pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_mode <= 1'b0;
        end else if (w_write && w_sel_mode) begin
            r_response_mode <= pwdata[0];
        end
    end

    assign prdata          = w_sel_mode ? APB_DATA_W'(r_response_mode) : '0;
    assign o_response_mode = r_response_mode;

endmodule

@@ rtl/hhsp_in_stage.sv @@
// ----------------------------------------------------------------------------
// hhsp_in_stage
// input register with valid/stall handshake
// ----------------------------------------------------------------------------
module hhsp_in_stage
    import hhsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_start_of_message,
    input  logic       i_adv,
    output logic       o_in_stall,
    output t_in_item   o_item
);

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_som;
    logic       w_accept;

    assign o_in_stall = r_valid && !i_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_byte <= i_data_byte;
            r_som       <= i_start_of_message;
        end
    end

    assign o_item = '{valid: r_valid, data_byte: r_data_byte, start_of_message: r_som};

endmodule

@@ rtl/hhsp_parse_core.sv @@
// ----------------------------------------------------------------------------
// hhsp_parse_core
// per-byte parse state update and result register
// ----------------------------------------------------------------------------
module hhsp_parse_core
    import hhsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_item,
    input  logic        i_adv,
    input  logic        i_response_mode,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [2:0]  o_byte_role,
    output logic        o_version_minor,
    output logic        o_is_chunked,
    output logic [31:0] o_content_length,
    output logic [15:0] o_status_code
);

    localparam int LW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

    // parse state
    t_phase        r_phase,   n_phase;
    logic [3:0]    r_col,     n_col;
    logic          r_first,   n_first;
    logic [1:0]    r_over,    n_over;
    logic          r_cr,      n_cr;
    logic          r_bad,     n_bad;
    logic          r_minor,   n_minor;
    logic          r_chunked, n_chunked;
    logic [LW-1:0] r_len,     n_len;
    logic [15:0]   r_code,    n_code;
    logic [1:0]    r_flags,   n_flags;
    logic [4:0]    r_mi,      n_mi;
    logic          r_vmc,     n_vmc;
    logic [LW-1:0] r_acc,     n_acc;
    logic [2:0]    n_role;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [2:0]  r_role;
    logic        r_minor_out;
    logic        r_chunked_out;
    logic [31:0] r_len_out;
    logic [15:0] r_code_out;

    logic w_fire;

    assign w_fire = i_item.valid && i_adv;

    always_comb begin
        logic [7:0]    v_byte;
        logic [7:0]    v_low;
        logic          v_digit;
        logic          v_space;
        logic          v_empty;
        logic [19:0]   v_code_prod;
        logic [LW+3:0] v_acc_prod;

        v_byte  = i_item.data_byte;
        v_low   = (v_byte >= CHAR_UP_A && v_byte <= CHAR_UP_Z) ? v_byte + 8'd32 : v_byte;
        v_digit = (v_byte >= CHAR_ZERO) && (v_byte <= CHAR_NINE);
        v_space = (v_byte == CHAR_SPACE) || (v_byte >= CHAR_TAB && v_byte <= CHAR_CR);
        v_empty = 1'b0;

        n_phase   = r_phase;
        n_col     = r_col;
        n_first   = r_first;
        n_over    = r_over;
        n_cr      = r_cr;
        n_bad     = r_bad;
        n_minor   = r_minor;
        n_chunked = r_chunked;
        n_len     = r_len;
        n_code    = r_code;
        n_flags   = r_flags;
        n_mi      = r_mi;
        n_vmc     = r_vmc;
        n_acc     = r_acc;
        n_role    = ROLE_FIRST;

        if (i_item.start_of_message) begin
            n_first   = 1'b0;
            n_over    = ST_PARSING;
            n_minor   = 1'b0;
            n_chunked = 1'b0;
            n_len     = '0;
            n_code    = '0;
            n_phase   = PH_F0;
            n_col     = '0;
            n_cr      = 1'b0;
            n_bad     = 1'b0;
            n_flags   = 2'b11;
            n_mi      = '0;
            n_vmc     = 1'b1;
            n_acc     = '0;
        end

        v_code_prod = ({4'b0, n_code} << 3) + ({4'b0, n_code} << 1) + 20'(v_byte[3:0]);
        v_acc_prod  = ({4'b0, n_acc} << 3) + ({4'b0, n_acc} << 1) + (LW+4)'(v_byte[3:0]);

        if (n_over == ST_PARSING) begin
            // held cr turns out to be line content
            if (n_cr && v_byte != CHAR_LF) begin
                unique case (n_phase) inside
                    PH_F0, PH_F1: begin
                        if (i_response_mode) n_bad = 1'b1;
                        if (n_col != COL_MAX) n_col = n_col + 4'd1;
                    end
                    PH_F2: begin
                        if (!i_response_mode) n_bad = 1'b1;
                        if (n_col != COL_MAX) n_col = n_col + 4'd1;
                    end
                    PH_NAME: begin
                        n_flags = 2'b00;
                        if (n_mi != MI_MAX) n_mi = n_mi + 5'd1;
                        if (n_col != COL_MAX) n_col = n_col + 4'd1;
                    end
                    PH_VSKIP: begin
                    end
                    PH_VALUE: begin
                        if (n_flags != 2'b00) n_vmc = 1'b0;
                        if (n_mi != MI_MAX) n_mi = n_mi + 5'd1;
                    end
                    default: begin
                    end
                endcase
                n_cr = 1'b0;
            end

            if (v_byte == CHAR_CR) begin
                n_cr   = 1'b1;
                n_role = ROLE_EOL;
            end else if (v_byte == CHAR_LF && n_cr) begin
                // end of line
                n_cr    = 1'b0;
                n_role  = ROLE_EOL;
                v_empty = (n_phase == (n_first ? PH_NAME : PH_F0)) && (n_col == '0);
                if (v_empty) begin
                    n_over = n_first ? ST_DONE : ST_ERROR;
                end else if (n_bad) begin
                    n_over = ST_ERROR;
                end else if (!n_first) begin
                    if (n_phase != PH_F2 || (!i_response_mode && n_col != VERS_COLS)) begin
                        n_over = ST_ERROR;
                    end else begin
                        n_first = 1'b1;
                    end
                end else if (n_phase == PH_NAME) begin
                    n_over = ST_ERROR;
                end else begin
                    if (n_flags[0] && n_vmc && n_mi == CHUNK_LEN) n_chunked = 1'b1;
                    if (n_flags[1] && n_vmc) n_len = n_acc;
                end
                n_phase = n_first ? PH_NAME : PH_F0;
                n_col   = '0;
                n_bad   = 1'b0;
                n_flags = 2'b11;
                n_mi    = '0;
                n_vmc   = 1'b1;
                n_acc   = '0;
            end else begin
                if (v_byte == 8'h00 || v_byte > HIGH_ASCII) n_bad = 1'b1;
                unique case (n_phase) inside
                    PH_F0: begin
                        if (v_byte == CHAR_SPACE) begin
                            if (i_response_mode && n_col != VERS_COLS) n_bad = 1'b1;
                            n_phase = PH_F1;
                            n_col   = '0;
                            n_role  = ROLE_SEP;
                        end else begin
                            if (i_response_mode) begin
                                if (n_col < VERS_LEN) begin
                                    if (v_byte != VERS_TEXT[n_col[2:0]]) n_bad = 1'b1;
                                end else if (n_col == VERS_LEN) begin
                                    if (v_byte == CHAR_ZERO) n_minor = 1'b0;
                                    else if (v_byte == CHAR_ONE) n_minor = 1'b1;
                                    else n_bad = 1'b1;
                                end else begin
                                    n_bad = 1'b1;
                                end
                            end
                            if (n_col != COL_MAX) n_col = n_col + 4'd1;
                            n_role = ROLE_FIRST;
                        end
                    end
                    PH_F1: begin
                        if (v_byte == CHAR_SPACE) begin
                            n_phase = PH_F2;
                            n_col   = '0;
                            n_role  = ROLE_SEP;
                        end else begin
                            if (i_response_mode) begin
                                if (v_digit) begin
                                    n_code = (v_code_prod[19:16] != 4'd0) ? 16'hffff
                                                                          : v_code_prod[15:0];
                                end else begin
                                    n_bad = 1'b1;
                                end
                            end
                            if (n_col != COL_MAX) n_col = n_col + 4'd1;
                            n_role = ROLE_MIDDLE;
                        end
                    end
                    PH_F2: begin
                        if (!i_response_mode) begin
                            if (n_col < VERS_LEN) begin
                                if (v_byte != VERS_TEXT[n_col[2:0]]) n_bad = 1'b1;
                            end else if (n_col == VERS_LEN) begin
                                if (v_byte == CHAR_ZERO) n_minor = 1'b0;
                                else if (v_byte == CHAR_ONE) n_minor = 1'b1;
                                else n_bad = 1'b1;
                            end else begin
                                n_bad = 1'b1;
                            end
                        end
                        if (n_col != COL_MAX) n_col = n_col + 4'd1;
                        n_role = ROLE_LAST;
                    end
                    PH_NAME: begin
                        if (v_byte == CHAR_COLON) begin
                            if (n_mi != TE_LEN) n_flags[0] = 1'b0;
                            if (n_mi != CL_LEN) n_flags[1] = 1'b0;
                            n_mi    = '0;
                            n_vmc   = 1'b1;
                            n_acc   = '0;
                            n_phase = PH_VSKIP;
                            n_role  = ROLE_SEP;
                        end else begin
                            if (n_mi >= TE_LEN || v_low != TE_NAME[n_mi]) n_flags[0] = 1'b0;
                            if (n_mi >= CL_LEN || v_low != CL_NAME[n_mi[3:0]]) begin
                                n_flags[1] = 1'b0;
                            end
                            if (n_mi != MI_MAX) n_mi = n_mi + 5'd1;
                            if (n_col != COL_MAX) n_col = n_col + 4'd1;
                            n_role = ROLE_NAME;
                        end
                    end
                    PH_VSKIP, PH_VALUE: begin
                        if (n_phase == PH_VSKIP && v_space) begin
                            n_role = ROLE_SEP;
                        end else begin
                            n_phase = PH_VALUE;
                            if (n_flags[0]) begin
                                if (n_mi >= CHUNK_LEN || v_low != CHUNK_WORD[n_mi[2:0]]) begin
                                    n_vmc = 1'b0;
                                end
                            end
                            if (n_flags[1]) begin
                                if (v_digit) begin
                                    n_acc = (v_acc_prod[LW+3:LW] != 4'd0) ? '1
                                                                          : v_acc_prod[LW-1:0];
                                end else begin
                                    n_vmc = 1'b0;
                                end
                            end
                            if (n_mi != MI_MAX) n_mi = n_mi + 5'd1;
                            n_role = ROLE_VALUE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_F0;
            r_col       <= '0;
            r_first     <= 1'b0;
            r_over      <= ST_PARSING;
            r_cr        <= 1'b0;
            r_bad       <= 1'b0;
            r_minor     <= 1'b0;
            r_chunked   <= 1'b0;
            r_len       <= '0;
            r_code      <= '0;
            r_flags     <= 2'b11;
            r_mi        <= '0;
            r_vmc       <= 1'b1;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_adv) begin
                r_out_valid <= i_item.valid;
            end
            if (w_fire) begin
                r_phase   <= n_phase;
                r_col     <= n_col;
                r_first   <= n_first;
                r_over    <= n_over;
                r_cr      <= n_cr;
                r_bad     <= n_bad;
                r_minor   <= n_minor;
                r_chunked <= n_chunked;
                r_len     <= n_len;
                r_code    <= n_code;
                r_flags   <= n_flags;
                r_mi      <= n_mi;
                r_vmc     <= n_vmc;
                r_acc     <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status      <= n_over;
            r_role        <= n_role;
            r_minor_out   <= n_minor;
            r_chunked_out <= n_chunked;
            r_len_out     <= 32'(n_len);
            r_code_out    <= n_code;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_byte_role      = r_role;
    assign o_version_minor  = r_minor_out;
    assign o_is_chunked     = r_chunked_out;
    assign o_content_length = r_len_out;
    assign o_status_code    = r_code_out;

endmodule

@@ rtl/http_header_stream_parser.sv @@
// ----------------------------------------------------------------------------
// http_header_stream_parser
// byte-serial http/1.x message head parser with apb configuration
// ----------------------------------------------------------------------------
// Takes one byte of an HTTP/1.x message head per cycle while o_in_stall is
// low and returns one result transaction per byte: parse status, the byte's
// role, the minor version, the chunked flag, the last Content-Length value
// (saturating at the smaller of 2^LENGTH_BITS-1 and 2^32-1) and the response
// status code. A byte goes from the input register through the state update
// into the result register, where its result transaction is held until it is
// taken. The input register and the result register each hold one
// transaction, so a stalled result still lets one more byte in before
// o_in_stall rises. Set start_of_message on the first byte of each message;
// write response_mode over APB (word 0) only while the block is idle. The
// block itself does not enforce this.
module http_header_stream_parser
    import hhsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_start_of_message,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [2:0]            o_byte_role,
    output logic                  o_version_minor,
    output logic                  o_is_chunked,
    output logic [31:0]           o_content_length,
    output logic [15:0]           o_status_code
);

    logic     w_response_mode;
    logic     w_adv;
    t_in_item w_item;

    assign w_adv = !o_out_valid || !i_out_stall;

    hhsp_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_response_mode (w_response_mode)
    );

    hhsp_in_stage u_in (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_data_byte        (i_data_byte),
        .i_start_of_message (i_start_of_message),
        .i_adv              (w_adv),
        .o_in_stall         (o_in_stall),
        .o_item             (w_item)
    );

    hhsp_parse_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (w_item),
        .i_adv            (w_adv),
        .i_response_mode  (w_response_mode),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_byte_role      (o_byte_role),
        .o_version_minor  (o_version_minor),
        .o_is_chunked     (o_is_chunked),
        .o_content_length (o_content_length),
        .o_status_code    (o_status_code)
    );

endmodule

@@ rtl/hhsp_checker.sv @@
// ----------------------------------------------------------------------------
// hhsp_checker
// port-level assertions for the http header stream parser
// ----------------------------------------------------------------------------
`include "http_header_stream_parser_macros.svh"

module hhsp_checker
    import hhsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [2:0]  o_byte_role,
    input logic        o_version_minor,
    input logic        o_is_chunked,
    input logic [31:0] o_content_length,
    input logic [15:0] o_status_code
);

    // input side only backs up behind a stalled result
    `HHSP_ASSERT_IMP(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // a finished head only shows on the line end or on ignored trailing bytes
    `HHSP_ASSERT_IMP(a_final_role,
        o_out_valid && o_status != ST_PARSING,
        o_byte_role == ROLE_EOL || o_byte_role == ROLE_FIRST)

    // a stalled result transaction holds
    `HHSP_ASSERT_NXT(a_out_hold,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_status) && $stable(o_byte_role)
            && $stable(o_version_minor) && $stable(o_is_chunked)
            && $stable(o_content_length) && $stable(o_status_code))

endmodule

bind http_header_stream_parser hhsp_checker u_checker (.*);

@@ bench/http_header_stream_parser_tb.sv @@
// ----------------------------------------------------------------------------
// http_header_stream_parser_tb
// self-checking bench for the byte-serial http/1.x message head parser
// ----------------------------------------------------------------------------
// Streams message heads through the parser one byte per transaction, in both
// request and response mode. A local model predicts every result transaction
// on input acceptance. The monitor compares each result field by field in
// order. Stimulus is a short directed set and then random heads, mostly well
// formed with random names, values, codes and versions, mixed with bad bytes,
// stray CR or LF, broken lines and restarts. Four flow-control profiles are
// used: free running, sender gaps, receiver stalls, and both.
module http_header_stream_parser_tb;
    import hhsp_pkg::*;

    localparam int LEN_BITS = LENGTH_BITS_DEF;
    localparam logic [31:0] LEN_LIMIT =
        (LEN_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << LEN_BITS) - 64'd1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 150;

    localparam logic [8*17-1:0] TE_TXT    = "transfer-encoding";
    localparam logic [8*14-1:0] CL_TXT    = "content-length";
    localparam logic [8*7-1:0]  CHUNK_TXT = "chunked";
    localparam logic [8*7-1:0]  VER_TXT   = "HTTP/1.";

    typedef struct packed {
        logic [7:0] data;
        logic       sol;
    } t_head_byte;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  role;
        logic        minor;
        logic        chunked;
        logic [31:0] clen;
        logic [15:0] code;
    } t_head_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  i_start_of_message = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_status;
    logic [2:0]            o_byte_role;
    logic                  o_version_minor;
    logic                  o_is_chunked;
    logic [31:0]           o_content_length;
    logic [15:0]           o_status_code;

    t_head_byte   bytes_to_send[$];
    t_head_result head_results_due[$];
    logic         next_sol = 1'b0;

    int cycle_count = 0;
    logic quiet_stretch = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int fail_count = 0;
    int messages_built = 0;
    int heads_done = 0;
    int heads_rejected = 0;

    // parser model state
    logic        resp_mode;
    t_phase      ln_phase;
    logic [3:0]  col_cnt;
    logic        first_ok;
    logic [1:0]  head_state;
    logic        cr_held;
    logic        bad_line;
    logic        minor_ver;
    logic        chunk_flag;
    logic [31:0] clen_val;
    logic [15:0] code_val;
    logic [1:0]  name_hits;
    logic [4:0]  match_pos;
    logic        chunk_ok;
    logic [31:0] digit_acc;

    http_header_stream_parser #(
        .LENGTH_BITS(LEN_BITS)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_byte        (i_data_byte),
        .i_start_of_message (i_start_of_message),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_byte_role        (o_byte_role),
        .o_version_minor    (o_version_minor),
        .o_is_chunked       (o_is_chunked),
        .o_content_length   (o_content_length),
        .o_status_code      (o_status_code)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? 8'(b + 8'd32) : b;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CHAR_ZERO && b <= CHAR_NINE;
    endfunction

    function automatic logic [7:0] text_char(input logic [8*17-1:0] txt, input int len,
                                             input int idx);
        if (idx >= len) return 8'h00;
        return txt[8*(len-1-idx) +: 8];
    endfunction

    function automatic void bump_column();
        if (col_cnt < COL_MAX) col_cnt = col_cnt + 4'd1;
    endfunction

    function automatic void clear_line_state();
        ln_phase  = first_ok ? PH_NAME : PH_F0;
        col_cnt   = 4'd0;
        cr_held   = 1'b0;
        bad_line  = 1'b0;
        name_hits = 2'b11;
        match_pos = 5'd0;
        chunk_ok  = 1'b1;
        digit_acc = 32'd0;
    endfunction

    function automatic void clear_message_state();
        first_ok   = 1'b0;
        head_state = ST_PARSING;
        minor_ver  = 1'b0;
        chunk_flag = 1'b0;
        clen_val   = 32'd0;
        code_val   = 16'd0;
        clear_line_state();
    endfunction

    function automatic void check_version_char(input logic [7:0] b);
        if (col_cnt < VERS_LEN) begin
            if (b != text_char((8*17)'(VER_TXT), 7, int'(col_cnt))) bad_line = 1'b1;
        end else if (col_cnt == VERS_LEN) begin
            if (b == CHAR_ZERO) minor_ver = 1'b0;
            else if (b == CHAR_ONE) minor_ver = 1'b1;
            else bad_line = 1'b1;
        end else begin
            bad_line = 1'b1;
        end
    endfunction

    function automatic void take_value_char(input logic [7:0] b);
        logic [7:0]  lb;
        logic [63:0] wide;
        lb = to_lower(b);
        if (name_hits[0]) begin
            if (match_pos >= CHUNK_LEN ||
                lb != text_char((8*17)'(CHUNK_TXT), 7, int'(match_pos)))
                chunk_ok = 1'b0;
        end
        if (name_hits[1]) begin
            if (is_digit(b)) begin
                wide = 64'(digit_acc) * 64'd10 + 64'(b - CHAR_ZERO);
                digit_acc = (wide > 64'(LEN_LIMIT)) ? LEN_LIMIT : wide[31:0];
            end else begin
                chunk_ok = 1'b0;
            end
        end
        if (match_pos < MI_MAX) match_pos = match_pos + 5'd1;
    endfunction

    function automatic logic [2:0] feed_head_char(input logic [7:0] b);
        logic [7:0]  lb;
        logic [31:0] nxt;
        logic [2:0]  role;
        lb = to_lower(b);
        role = ROLE_FIRST;
        if (b == 8'h00 || b > HIGH_ASCII) bad_line = 1'b1;
        case (ln_phase)
            PH_F0: begin
                if (b == CHAR_SPACE) begin
                    if (resp_mode && col_cnt != VERS_COLS) bad_line = 1'b1;
                    ln_phase = PH_F1;
                    col_cnt = 4'd0;
                    role = ROLE_SEP;
                end else begin
                    if (resp_mode) check_version_char(b);
                    bump_column();
                    role = ROLE_FIRST;
                end
            end
            PH_F1: begin
                if (b == CHAR_SPACE) begin
                    ln_phase = PH_F2;
                    col_cnt = 4'd0;
                    role = ROLE_SEP;
                end else begin
                    if (resp_mode) begin
                        if (is_digit(b)) begin
                            nxt = 32'(code_val) * 32'd10 + 32'(b - CHAR_ZERO);
                            code_val = (nxt > 32'd65535) ? 16'hFFFF : nxt[15:0];
                        end else begin
                            bad_line = 1'b1;
                        end
                    end
                    bump_column();
                    role = ROLE_MIDDLE;
                end
            end
            PH_F2: begin
                if (!resp_mode) check_version_char(b);
                bump_column();
                role = ROLE_LAST;
            end
            PH_NAME: begin
                if (b == CHAR_COLON) begin
                    if (match_pos != TE_LEN) name_hits[0] = 1'b0;
                    if (match_pos != CL_LEN) name_hits[1] = 1'b0;
                    match_pos = 5'd0;
                    chunk_ok = 1'b1;
                    digit_acc = 32'd0;
                    ln_phase = PH_VSKIP;
                    role = ROLE_SEP;
                end else begin
                    if (match_pos >= TE_LEN ||
                        lb != text_char(TE_TXT, 17, int'(match_pos)))
                        name_hits[0] = 1'b0;
                    if (match_pos >= CL_LEN ||
                        lb != text_char((8*17)'(CL_TXT), 14, int'(match_pos)))
                        name_hits[1] = 1'b0;
                    if (match_pos < MI_MAX) match_pos = match_pos + 5'd1;
                    bump_column();
                    role = ROLE_NAME;
                end
            end
            PH_VSKIP: begin
                if (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)) begin
                    role = ROLE_SEP;
                end else begin
                    ln_phase = PH_VALUE;
                    take_value_char(b);
                    role = ROLE_VALUE;
                end
            end
            default: begin
                take_value_char(b);
                role = ROLE_VALUE;
            end
        endcase
        return role;
    endfunction

    function automatic void close_line();
        logic blank;
        blank = (ln_phase == (first_ok ? PH_NAME : PH_F0)) && (col_cnt == 4'd0);
        if (blank) begin
            head_state = first_ok ? ST_DONE : ST_ERROR;
        end else if (bad_line) begin
            head_state = ST_ERROR;
        end else if (!first_ok) begin
            if (ln_phase != PH_F2 || (!resp_mode && col_cnt != VERS_COLS))
                head_state = ST_ERROR;
            else
                first_ok = 1'b1;
        end else if (ln_phase == PH_NAME) begin
            head_state = ST_ERROR;
        end else begin
            if (name_hits[0] && chunk_ok && match_pos == CHUNK_LEN) chunk_flag = 1'b1;
            if (name_hits[1] && chunk_ok) clen_val = digit_acc;
        end
        if (head_state == ST_DONE) heads_done++;
        else if (head_state == ST_ERROR) heads_rejected++;
        clear_line_state();
    endfunction

    function automatic t_head_result predict_byte(input logic [7:0] b, input logic sol);
        t_head_result r;
        logic [2:0]   role;
        role = ROLE_FIRST;
        if (sol) clear_message_state();
        if (head_state == ST_PARSING) begin
            if (b == CHAR_CR) begin
                if (cr_held) void'(feed_head_char(CHAR_CR));
                cr_held = 1'b1;
                role = ROLE_EOL;
            end else if (b == CHAR_LF && cr_held) begin
                cr_held = 1'b0;
                close_line();
                role = ROLE_EOL;
            end else begin
                if (cr_held) begin
                    void'(feed_head_char(CHAR_CR));
                    cr_held = 1'b0;
                end
                role = feed_head_char(b);
            end
        end
        r.status  = head_state;
        r.role    = role;
        r.minor   = minor_ver;
        r.chunked = chunk_flag;
        r.clen    = clen_val;
        r.code    = code_val;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch at result %0d: %s got %0h want %0h",
                     results_seen, what, got, want);
    endtask

    task automatic queue_byte(input logic [7:0] b);
        t_head_byte item;
        item.data = b;
        item.sol = next_sol;
        bytes_to_send = {bytes_to_send, item};
        next_sol = 1'b0;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic queue_eol();
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1)) return 8'(CHAR_UP_A + $urandom_range(0, 25));
        return 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic maybe_noise();
        case ($urandom_range(0, 119))
            0: queue_byte(8'h00);
            1: queue_byte(8'($urandom_range(128, 255)));
            2: queue_byte(CHAR_CR);
            3: queue_byte(CHAR_LF);
            4: queue_byte(8'($urandom_range(0, 255)));
            5: queue_byte(HIGH_ASCII);
            6: next_sol = 1'b1;
            default: ;
        endcase
    endtask

    task automatic queue_version();
        case ($urandom_range(0, 31))
            0: queue_text("HTTP/1.2");
            1: queue_text("HTTP/1.10");
            2: queue_text("HTTP/1.");
            3: queue_text("http/1.1");
            default: begin
                queue_text("HTTP/1.");
                queue_byte($urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO);
            end
        endcase
    endtask

    task automatic gen_message(input logic status_style);
        int kind;
        next_sol = 1'b1;
        messages_built++;
        if ($urandom_range(0, 15) == 0) status_style = !status_style;
        if (status_style) begin
            queue_version();
            queue_byte(CHAR_SPACE);
            case ($urandom_range(0, 7))
                0: ;
                1: repeat ($urandom_range(5, 8)) queue_byte(rand_digit());
                2: begin
                    queue_byte(rand_digit());
                    queue_byte(rand_letter());
                end
                default: repeat (3) queue_byte(rand_digit());
            endcase
            maybe_noise();
            if ($urandom_range(0, 15) != 0) queue_byte(CHAR_SPACE);
            repeat ($urandom_range(0, 6))
                queue_byte($urandom_range(0, 3) == 0 ? CHAR_SPACE : rand_letter());
        end else begin
            repeat ($urandom_range(0, 6)) queue_byte(rand_letter());
            maybe_noise();
            queue_byte(CHAR_SPACE);
            repeat ($urandom_range(0, 6)) queue_byte(8'($urandom_range(33, 126)));
            if ($urandom_range(0, 15) != 0) queue_byte(CHAR_SPACE);
            queue_version();
        end
        maybe_noise();
        queue_eol();
        repeat ($urandom_range(0, 4)) begin
            kind = $urandom_range(0, 11);
            case (kind)
                0: queue_text("Transfer-Encoding");
                1: queue_text("transfer-encoding");
                2: queue_text("TRANSFER-ENCODING");
                3: queue_text("Transfer-Encodings");
                4: queue_text("Content-Length");
                5: queue_text("content-length");
                6: queue_text("CONTENT-LENGTH");
                7: queue_text("Content-Lengt");
                8: queue_text("Host");
                default: repeat ($urandom_range(0, 20))
                    queue_byte($urandom_range(0, 7) == 0 ? 8'h2d : rand_letter());
            endcase
            maybe_noise();
            if ($urandom_range(0, 23) != 0) queue_byte(CHAR_COLON);
            repeat ($urandom_range(0, 2))
                queue_byte($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
            if (kind <= 3) begin
                case ($urandom_range(0, 7))
                    0: queue_text("Chunked");
                    1: queue_text("CHUNKED");
                    2: queue_text("chunke");
                    3: queue_text("chunkedx");
                    4: queue_text("gzip");
                    5: ;
                    default: queue_text("chunked");
                endcase
            end else if (kind <= 7) begin
                case ($urandom_range(0, 7))
                    0: ;
                    1: repeat ($urandom_range(10, 14)) queue_byte(rand_digit());
                    2: begin
                        queue_byte(rand_digit());
                        queue_byte(rand_letter());
                        queue_byte(rand_digit());
                    end
                    default: repeat ($urandom_range(1, 6)) queue_byte(rand_digit());
                endcase
            end else begin
                repeat ($urandom_range(0, 10)) queue_byte(8'($urandom_range(32, 126)));
            end
            if ($urandom_range(0, 11) == 0) queue_byte(CHAR_SPACE);
            maybe_noise();
            queue_eol();
        end
        if ($urandom_range(0, 11) != 0) queue_eol();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic write_mode(input logic mode);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_RESPONSE_MODE, 2'b00};
        pwdata  <= ($urandom() & ~32'd1) | 32'(mode);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        resp_mode = mode;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (bytes_to_send.size() != 0 || i_in_valid || head_results_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // input driver and acceptance tracking
    always @(posedge i_clk) begin
        t_head_byte   nxt;
        t_head_result due;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due = predict_byte(i_data_byte, i_start_of_message);
                head_results_due = {head_results_due, due};
                bytes_taken++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (bytes_to_send.size() != 0 &&
                    $urandom_range(0, 99) >= (quiet_stretch ? 0 : send_idle_pct)) begin
                    nxt = bytes_to_send[0];
                    bytes_to_send.delete(0);
                    i_in_valid <= 1'b1;
                    i_data_byte <= nxt.data;
                    i_start_of_message <= nxt.sol;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_head_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (head_results_due.size() == 0) begin
                report_mismatch("result transaction with none due", 32'd0, 32'd0);
            end else begin
                want = head_results_due[0];
                head_results_due.delete(0);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_byte_role !== want.role)
                    report_mismatch("byte_role", o_byte_role, want.role);
                if (o_version_minor !== want.minor)
                    report_mismatch("version_minor", o_version_minor, want.minor);
                if (o_is_chunked !== want.chunked)
                    report_mismatch("is_chunked", o_is_chunked, want.chunked);
                if (o_content_length !== want.clen)
                    report_mismatch("content_length", o_content_length, want.clen);
                if (o_status_code !== want.code)
                    report_mismatch("status_code", o_status_code, want.code);
            end
        end
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= ($urandom_range(0, 99) < (quiet_stretch ? 0 : recv_stall_pct));
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        quiet_stretch <= (cycle_count % 240) < 40;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results due", cycle_count,
                     head_results_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        resp_mode = 1'b0;
        clear_message_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int prof = 0; prof < 4; prof++) begin
            for (int m = 0; m < 2; m++) begin
                wait_drained();
                write_mode(m[0]);
                @(negedge i_clk);
                send_idle_pct  = (prof == 1) ? 57 : (prof == 3) ? 35 : 0;
                recv_stall_pct = (prof == 2) ? 57 : (prof == 3) ? 35 : 0;
                if (prof == 0 && m == 0) begin
                    // blank first line, then bytes ignored after the end
                    next_sol = 1'b1;
                    queue_eol();
                    queue_byte(8'hff);
                    queue_byte(8'h00);
                    next_sol = 1'b1;
                    queue_text("GET / HTTP/1.1");
                    queue_eol();
                    queue_eol();
                end else if (prof == 0) begin
                    // saturating status code, then a line holding a bad byte
                    next_sol = 1'b1;
                    queue_text("HTTP/1.0 99999 ");
                    queue_eol();
                    queue_eol();
                    next_sol = 1'b1;
                    queue_byte(HIGH_ASCII);
                    queue_byte(8'h80);
                    queue_eol();
                end
                while (bytes_to_send.size() < PHASE_BYTES) gen_message(m[0]);
            end
        end
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("checked %0d of %0d bytes from %0d heads in request and response mode",
                 results_seen, bytes_taken, messages_built);
        $display("heads completed %0d, rejected %0d, over four flow-control profiles",
                 heads_done, heads_rejected);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ http_header_stream_parser.f @@
+incdir+rtl
rtl/hhsp_pkg.sv
rtl/hhsp_apb_regs.sv
rtl/hhsp_in_stage.sv
rtl/hhsp_parse_core.sv
rtl/http_header_stream_parser.sv
rtl/hhsp_checker.sv
bench/http_header_stream_parser_tb.sv
